// ----- src/vrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrm_pkg
// Shared types and constants of the voxel ray marcher.
// ----------------------------------------------------------------------------
package vrm_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int DEF_GRID_X    = 16;
   localparam int DEF_GRID_Y    = 16;
   localparam int DEF_GRID_Z    = 16;
   localparam int DEF_MAX_STEPS = 64;

   localparam int POS_W   = FRACTION_BITS + 10;        // covers 256 cells plus one overshoot
   localparam int DIST_W  = FRACTION_BITS + 2;          // step length, capped at 2.0 + eps
   localparam int DEN_W   = 18;                         // |dir| fits 18 unsigned bits
   localparam int NUM_W   = 2 * FRACTION_BITS + 1;      // (1 - frac) << F
   localparam int QUO_W   = 18;                         // quotient bits worth computing
   localparam int WIDE_W  = DEN_W + QUO_W;              // divisor shifted to the top bit
   localparam int PROD_W  = DIST_W + 1 + DEN_W;
   localparam int KCNT_W  = $clog2(QUO_W);

   localparam logic [FRACTION_BITS:0] ONE_FX  = (FRACTION_BITS + 1)'(1 << FRACTION_BITS);
   localparam logic [DIST_W-1:0]      EPS_FX  =
      DIST_W'(((1 << FRACTION_BITS) + 50) / 100);
   localparam logic [DIST_W-1:0]      CAP_FX  = DIST_W'(2 << FRACTION_BITS);
   localparam logic [15:0]            BORDER_RESET = 16'd3277;

   localparam logic [7:0] BLANK_CODE = 8'd32;
   localparam logic [7:0] EDGE_CODE  = 8'd45;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TRACE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DIV_START,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

endpackage

// ----- src/voxel_ray_march.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_march
// Voxel grid store with a ray marcher built around one shared divider and
// one shared multiplier.
//
// Channel   Direction  Handshake              Beat
// req_      in         req_valid / req_stall  one cell write or one ray trace
// rsp_      out        rsp_valid / rsp_stall  pixel code and step cap flag
// csr_      in         csr_write_enable       border width, no read-back
//
// A cell write is done as it is accepted. A trace runs, per cell marched,
// one restoring division (skipped where it cannot beat the cap) and one
// multiply per axis, and marches at most MAX_STEPS cells.
// After reset the store is swept to blank, one cell a cycle, and req_stall
// stays high meanwhile.
// A finished trace waits in its own register while a held rsp_ beat is stalled.
// ----------------------------------------------------------------------------
module voxel_ray_march
   import vrm_pkg::*;
#(
   parameter int GRID_X    = DEF_GRID_X,
   parameter int GRID_Y    = DEF_GRID_Y,
   parameter int GRID_Z    = DEF_GRID_Z,
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [3:0]         req_cell_x,
   input  logic [3:0]         req_cell_y,
   input  logic [3:0]         req_cell_z,
   input  logic [7:0]         req_cell_value,
   input  logic signed [23:0] req_origin_x,
   input  logic signed [23:0] req_origin_y,
   input  logic signed [23:0] req_origin_z,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic signed [17:0] req_dir_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_pixel_code,
   output logic               rsp_step_limit_hit,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);

   localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int F      = FRACTION_BITS;

   localparam logic signed [POS_W-1:0] LIM_X = POS_W'(GRID_X * (1 << F));
   localparam logic signed [POS_W-1:0] LIM_Y = POS_W'(GRID_Y * (1 << F));
   localparam logic signed [POS_W-1:0] LIM_Z = POS_W'(GRID_Z * (1 << F));

   state_type state_ff, state_in;

   logic [7:0]                mem [CELLS];
   logic [7:0]                rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [7:0]                mem_wdata;

   logic [ADDR_W-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [15:0]               border_ff;

   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [POS_W-1:0]   pos_in [3];
   logic signed [DEN_W-1:0]   dir_ff [3];
   logic signed [DEN_W-1:0]   dir_in [3];
   logic [1:0]                ax_ff, ax_in;
   logic [STEP_W-1:0]         step_cnt_ff, step_cnt_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [NUM_W-1:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [KCNT_W-1:0]         k_ff, k_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [7:0]                res_code_ff, res_code_in;
   logic                      res_flag_ff, res_flag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_code_ff, rsp_code_in;
   logic                      rsp_flag_ff, rsp_flag_in;

   logic                      req_accept;
   logic                      outside;
   logic                      near_edge;
   logic                      hit;
   logic                      at_cap;
   logic                      rsp_free;
   logic signed [POS_W-1:0]   cur_pos;
   logic signed [DEN_W-1:0]   cur_dir;
   logic [F-1:0]              cur_frac;
   logic                      dir_pos;
   logic                      dir_neg;
   logic [DEN_W-1:0]          cur_den;
   logic [NUM_W-1:0]          cur_num;
   logic                      axis_skip;
   logic [WIDE_W-1:0]         div_sub;
   logic                      div_take;
   logic [QUO_W-1:0]          quo_next;
   logic                      div_last;
   logic [1:0]                edge_cnt;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign at_cap     = (step_cnt_ff == STEP_W'(MAX_STEPS));
   assign hit        = (rd_data_ff != BLANK_CODE);

   // --- position tests
   always_comb begin
      logic [F:0] d;
      outside = (pos_ff[0] < 0) || (pos_ff[0] >= LIM_X) ||
                (pos_ff[1] < 0) || (pos_ff[1] >= LIM_Y) ||
                (pos_ff[2] < 0) || (pos_ff[2] >= LIM_Z);
      edge_cnt = 2'd0;
      for (int a = 0; a < 3; a++) begin
         d = ONE_FX - {1'b0, pos_ff[a][F-1:0]};
         if ({1'b0, pos_ff[a][F-1:0]} < d) begin
            d = {1'b0, pos_ff[a][F-1:0]};
         end
         if (d < {1'b0, border_ff}) begin
            edge_cnt = edge_cnt + 2'd1;
         end
      end
      near_edge = (edge_cnt >= 2'd2);
   end

   assign rd_addr = ADDR_W'((32'(pos_ff[2][F+7:F]) * GRID_Y + 32'(pos_ff[1][F+7:F])) * GRID_X
                            + 32'(pos_ff[0][F+7:F]));

   // --- shared divider operands
   always_comb begin
      logic signed [DEN_W:0] neg_dir;
      cur_pos  = pos_ff[ax_ff];
      cur_dir  = dir_ff[ax_ff];
      cur_frac = cur_pos[F-1:0];
      dir_pos  = (cur_dir > $signed({1'b0, EPS_FX}));
      dir_neg  = (cur_dir < -$signed({1'b0, EPS_FX}));
      neg_dir  = -{cur_dir[DEN_W-1], cur_dir};
      cur_den  = dir_neg ? neg_dir[DEN_W-1:0] : cur_dir;
      cur_num  = dir_pos ? {ONE_FX - {1'b0, cur_frac}, {F{1'b0}}}
                         : NUM_W'({cur_frac, {F{1'b0}}});
      // a quotient of 2^QUO_W or more never beats the cap
      axis_skip = !(dir_pos || dir_neg) ||
                  ({{(WIDE_W-NUM_W){1'b0}}, cur_num} >= {cur_den, {QUO_W{1'b0}}});
      div_sub  = WIDE_W'(den_ff) << k_ff;
      div_take = ({{(WIDE_W-NUM_W){1'b0}}, rem_ff} >= div_sub);
      quo_next = quo_ff | (div_take ? (QUO_W'(1) << k_ff) : '0);
      div_last = (k_ff == '0);
   end

   // --- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept && req_type == REQ_TRACE) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (outside || at_cap) ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = hit ? ST_DONE : ST_DIV_START;
         end
         ST_DIV_START: begin
            if (!axis_skip)          state_in = ST_DIV;
            else if (ax_ff == 2'd2)  state_in = ST_MUL;
         end
         ST_DIV: begin
            if (div_last) state_in = (ax_ff == 2'd2) ? ST_MUL : ST_DIV_START;
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: state_in = (ax_ff == 2'd2) ? ST_CHECK : ST_MUL;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // --- datapath and outputs
   always_comb begin
      logic [DIST_W-1:0] dist_eps;
      clr_cnt_in   = clr_cnt_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      ax_in        = ax_ff;
      step_cnt_in  = step_cnt_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      res_code_in  = res_code_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_flag_in  = rsp_flag_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_cnt_ff;
      mem_wdata    = BLANK_CODE;
      dist_eps     = dist_ff + EPS_FX;

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_accept && req_type == REQ_WRITE) begin
               mem_we    = ({5'd0, req_cell_x} < 9'(GRID_X)) &&
                           ({5'd0, req_cell_y} < 9'(GRID_Y)) &&
                           ({5'd0, req_cell_z} < 9'(GRID_Z));
               mem_waddr = ADDR_W'((32'(req_cell_z) * GRID_Y + 32'(req_cell_y)) * GRID_X
                                   + 32'(req_cell_x));
               mem_wdata = req_cell_value;
            end
            pos_in[0]   = POS_W'(req_origin_x);
            pos_in[1]   = POS_W'(req_origin_y);
            pos_in[2]   = POS_W'(req_origin_z);
            dir_in[0]   = req_dir_x;
            dir_in[1]   = req_dir_y;
            dir_in[2]   = req_dir_z;
            step_cnt_in = '0;
         end
         ST_CHECK: begin
            res_code_in = BLANK_CODE;
            res_flag_in = !outside;
            ax_in       = 2'd0;
            dist_in     = CAP_FX;
         end
         ST_READ: begin
            res_code_in = near_edge ? EDGE_CODE : rd_data_ff;
            res_flag_in = 1'b0;
         end
         ST_DIV_START: begin
            rem_in = cur_num;
            quo_in = '0;
            den_in = cur_den;
            k_in   = KCNT_W'(QUO_W - 1);
            if (axis_skip) ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         ST_DIV: begin
            if (div_take) rem_in = rem_ff - NUM_W'(div_sub);
            quo_in = quo_next;
            k_in   = k_ff - KCNT_W'(1);
            if (div_last) begin
               if ({{(DIST_W > QUO_W ? DIST_W - QUO_W : 0){1'b0}}, quo_next} < dist_ff) begin
                  dist_in = DIST_W'(quo_next);
               end
               ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end
         end
         ST_MUL: begin
            prod_in = $signed({1'b0, dist_eps}) * cur_dir;
         end
         ST_ADD: begin
            // arithmetic shift floors toward minus infinity
            pos_in[ax_ff] = cur_pos + POS_W'(prod_ff >>> F);
            if (ax_ff == 2'd2) begin
               ax_in       = 2'd0;
               step_cnt_in = step_cnt_ff + STEP_W'(1);
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_flag_in  = res_flag_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         border_ff    <= BORDER_RESET;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= 2'd0;
         step_cnt_ff  <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         if (csr_write_enable) border_ff <= csr_write_data;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
         step_cnt_ff  <= step_cnt_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      dir_ff      <= dir_in;
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      res_code_ff <= res_code_in;
      res_flag_ff <= res_flag_in;
      rsp_code_ff <= rsp_code_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_code     = rsp_code_ff;
   assign rsp_step_limit_hit = rsp_flag_ff;

   // --- checks
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_cnt_ff <= STEP_W'(MAX_STEPS))
      else $error("step count beyond cap");

   a_dist_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (dist_ff <= CAP_FX))
      else $error("step length above cap");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |->
         ({{(WIDE_W-NUM_W+1){1'b0}}, rem_ff} < ({1'b0, div_sub} << 1)))
      else $error("divider remainder out of range");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_free) |=> (state_ff == ST_DONE && rsp_valid_ff))
      else $error("result lost while output held");

endmodule
